[hdl/irpd_pkg.sv]
// shared types and constants for the ir remote pulse decoder
// item structs, port codes, one-hot phase type and pulse width windows
// no dependencies
package irpd_pkg;

  // ports selected by req_type
  localparam logic [1:0] PORT_REMOTE     = 2'd0;
  localparam logic [1:0] PORT_MUTE_LEFT  = 2'd1;
  localparam logic [1:0] PORT_MUTE_RIGHT = 2'd2;

  // decoder phase codes as reported on the result
  localparam logic [2:0] PH_CODE_IDLE      = 3'd0;
  localparam logic [2:0] PH_CODE_HDR_PULSE = 3'd1;
  localparam logic [2:0] PH_CODE_HDR_SPACE = 3'd2;
  localparam logic [2:0] PH_CODE_BIT_PULSE = 3'd3;
  localparam logic [2:0] PH_CODE_BIT_SPACE = 3'd4;

  // pulse width windows in microseconds, lower bound inclusive, upper exclusive
  localparam logic [15:0] HDR_PULSE_MIN = 16'd5800;
  localparam logic [15:0] HDR_PULSE_MAX = 16'd11200;
  localparam logic [15:0] HDR_SPACE_MIN = 16'd3400;
  localparam logic [15:0] HDR_SPACE_MAX = 16'd6200;
  localparam logic [15:0] BIT_PULSE_MIN = 16'd380;
  localparam logic [15:0] BIT_PULSE_MAX = 16'd1070;
  localparam logic [15:0] ONE_SPACE_MIN = 16'd1260;
  localparam logic [15:0] ONE_SPACE_MAX = 16'd4720;
  localparam logic [15:0] ZERO_SPACE_MIN = 16'd300;
  localparam logic [15:0] ZERO_SPACE_MAX = 16'd1065;

  localparam logic [7:0] DEVICE_ADDRESS_RESET = 8'hA8;
  localparam logic [5:0] FRAME_BITS = 6'd32;

  typedef enum logic [4:0] {
    PH_IDLE      = 5'b00001,
    PH_HDR_PULSE = 5'b00010,
    PH_HDR_SPACE = 5'b00100,
    PH_BIT_PULSE = 5'b01000,
    PH_BIT_SPACE = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic        line_level;
    logic [15:0] elapsed_us;
  } in_item_t;

  typedef struct packed {
    logic       command_valid;
    logic [7:0] command_code;
    logic       mute_left;
    logic       mute_right;
    logic [2:0] decoder_phase;
  } out_item_t;

endpackage

[hdl/ir_remote_pulse_decoder_unit.sv]
// ir remote pulse decoder top level
// times the pulses and spaces of an nec style remote line and keeps two mute flags
// depends on irpd_pkg
//
// usage
//   input channel in_valid / in_ready / in_data: one transfer is one write to a port,
//   req_type 0 the remote line level with the microseconds since the previous edge,
//   1 the left mute flag, 2 the right mute flag, 3 ignored
//   result channel out_valid / out_ready / out_data: exactly one result per input
//   transfer, in order, carrying the frame command (when this write finished an
//   accepted frame), both mute flags and the decoder phase after the write
//   config channel cfg_valid / cfg_ready / cfg_data: device address byte, always ready,
//   to be written while no item is in flight
// timing
//   an accepted item sits in the input register and is decoded combinationally there;
//   its result is loaded into the result register, which drives out_valid
//   one item per cycle while out_ready is high; the input and result registers set it
// reset
//   rst_n low at a clock edge empties both registers, clears the decoder to idle,
//   clears the mute flags and loads device address 0xA8
// stall
//   while out_ready is low and a result waits, the input register holds its item and
//   in_ready drops once that register is full; nothing is lost or repeated
module ir_remote_pulse_decoder_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  irpd_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output irpd_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_data
);
  import irpd_pkg::*;

  // pipeline registers
  logic      s1_valid_r;
  in_item_t  s1_item_r;
  logic      out_valid_r;
  out_item_t out_item_r;

  // decoder state
  logic [7:0]  dev_addr_r;
  logic        last_level_r, last_level_nxt;
  phase_t      phase_r, phase_nxt;
  logic [31:0] shift_r, shift_nxt;
  logic [5:0]  count_r, count_nxt;
  logic        mute_l_r, mute_l_nxt;
  logic        mute_r_r, mute_r_nxt;

  logic      out_free;
  logic      s1_adv;
  logic      frame_ok;
  logic      t_one, t_bad;
  logic [15:0] t_us;
  logic [2:0]  phase_code;
  out_item_t out_item_nxt;

  // handshake: result register frees when empty or taken, input register follows
  assign out_free  = !out_valid_r || out_ready;
  assign s1_adv    = s1_valid_r && out_free;
  assign in_ready  = !s1_valid_r || out_free;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  assign t_us  = s1_item_r.elapsed_us;
  // long space is a one, mid space a zero, anything else drops the frame
  assign t_one = (t_us >= ONE_SPACE_MIN) && (t_us < ONE_SPACE_MAX);
  assign t_bad = !t_one && ((t_us < ZERO_SPACE_MIN) || (t_us >= ZERO_SPACE_MAX));

  // decode one write against the current state
  always_comb begin
    last_level_nxt = last_level_r;
    phase_nxt      = phase_r;
    shift_nxt      = shift_r;
    count_nxt      = count_r;
    mute_l_nxt     = mute_l_r;
    mute_r_nxt     = mute_r_r;
    frame_ok       = 1'b0;
    priority if (s1_item_r.req_type == PORT_REMOTE) begin
      if (s1_item_r.line_level != last_level_r) begin
        last_level_nxt = s1_item_r.line_level;
        unique case (phase_r)
          PH_IDLE: begin
            // only a rising edge starts a frame
            if (s1_item_r.line_level) begin
              shift_nxt = '0;
              count_nxt = '0;
              phase_nxt = PH_HDR_PULSE;
            end
          end
          PH_HDR_PULSE: begin
            phase_nxt = ((t_us >= HDR_PULSE_MIN) && (t_us < HDR_PULSE_MAX)) ?
                        PH_HDR_SPACE : PH_IDLE;
          end
          PH_HDR_SPACE: begin
            phase_nxt = ((t_us >= HDR_SPACE_MIN) && (t_us < HDR_SPACE_MAX)) ?
                        PH_BIT_PULSE : PH_IDLE;
          end
          PH_BIT_PULSE: begin
            phase_nxt = ((t_us >= BIT_PULSE_MIN) && (t_us < BIT_PULSE_MAX)) ?
                        PH_BIT_SPACE : PH_IDLE;
          end
          PH_BIT_SPACE: begin
            if (t_bad) begin
              phase_nxt = PH_IDLE;
            end else begin
              if (t_one && (count_r < FRAME_BITS)) begin
                shift_nxt = shift_r | (32'd1 << count_r[4:0]);
              end
              if (count_r == FRAME_BITS) begin
                // closing space, its bit is dropped
                frame_ok  = (shift_r[7:0] == ~shift_r[15:8]) &&
                            (shift_r[7:0] == dev_addr_r) &&
                            (shift_r[23:16] == ~shift_r[31:24]);
                phase_nxt = PH_IDLE;
              end else begin
                phase_nxt = PH_BIT_PULSE;
              end
              count_nxt = count_r + 6'd1;
            end
          end
          default: begin
            phase_nxt = phase_r;
          end
        endcase
      end
    end else if (s1_item_r.req_type == PORT_MUTE_LEFT) begin
      mute_l_nxt = s1_item_r.line_level;
    end else if (s1_item_r.req_type == PORT_MUTE_RIGHT) begin
      mute_r_nxt = s1_item_r.line_level;
    end else begin
      // unused port, no change
      mute_l_nxt = mute_l_r;
    end
  end

  always_comb begin
    unique case (phase_nxt)
      PH_IDLE:      phase_code = PH_CODE_IDLE;
      PH_HDR_PULSE: phase_code = PH_CODE_HDR_PULSE;
      PH_HDR_SPACE: phase_code = PH_CODE_HDR_SPACE;
      PH_BIT_PULSE: phase_code = PH_CODE_BIT_PULSE;
      PH_BIT_SPACE: phase_code = PH_CODE_BIT_SPACE;
      default:      phase_code = PH_CODE_IDLE;
    endcase
  end

  always_comb begin
    out_item_nxt.command_valid = frame_ok;
    out_item_nxt.command_code  = frame_ok ? shift_nxt[23:16] : 8'd0;
    out_item_nxt.mute_left     = mute_l_nxt;
    out_item_nxt.mute_right    = mute_r_nxt;
    out_item_nxt.decoder_phase = phase_code;
  end

  // control and decoder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      dev_addr_r   <= DEVICE_ADDRESS_RESET;
      last_level_r <= 1'b0;
      phase_r      <= PH_IDLE;
      shift_r      <= '0;
      count_r      <= '0;
      mute_l_r     <= 1'b0;
      mute_r_r     <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
      if (cfg_valid && cfg_ready) begin
        dev_addr_r <= cfg_data;
      end
      if (s1_adv) begin
        last_level_r <= last_level_nxt;
        phase_r      <= phase_nxt;
        shift_r      <= shift_nxt;
        count_r      <= count_nxt;
        mute_l_r     <= mute_l_nxt;
        mute_r_r     <= mute_r_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item_r <= in_data;
    end
    if (s1_adv) begin
      out_item_r <= out_item_nxt;
    end
  end

  // an accepted frame always leaves the decoder idle
  a_frame_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.command_valid) |->
      (out_item_r.decoder_phase == PH_CODE_IDLE))
    else $error("accepted frame without return to idle");

  // no command code without a command
  a_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_item_r.command_valid) |-> (out_item_r.command_code == 8'd0))
    else $error("command code set without accepted frame");

  // bit counter stops one past the closing space
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (FRAME_BITS + 6'd1))
    else $error("bit counter out of range");

  // a stalled item stays in the input register
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_free) |=> (s1_valid_r && $stable(s1_item_r)))
    else $error("input register lost an item under stall");

endmodule

[tb/ir_remote_pulse_decoder_unit_tb.sv]
`timescale 1ns / 100ps
// self-checking testbench for ir_remote_pulse_decoder_unit: directed table, then random frames
// compares every result to a typed-in row or the decoder model; depends on irpd_pkg and the dut
module ir_remote_pulse_decoder_unit_tb;
  import irpd_pkg::*;

  // req_type value that selects no port at all
  localparam logic [1:0] PORT_UNUSED = 2'd3;

  // one row of the directed table: the write, whether a result is typed in, and that result
  typedef struct packed {
    in_item_t  item;
    logic      chk;
    out_item_t res;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [7:0] cfg_data = 8'h00;

  ir_remote_pulse_decoder_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // decoder model state, mirrors the block after each accepted write
  logic [7:0]  dev_addr = DEVICE_ADDRESS_RESET;
  logic        lvl_q = 1'b0;
  logic [2:0]  phase_q = PH_CODE_IDLE;
  logic [31:0] frame_bits = '0;
  logic [5:0]  bits_seen = '0;
  logic        left_q = 1'b0;
  logic        right_q = 1'b0;

  // results still owed by the dut, oldest first
  out_item_t reports_due [$];

  int errors = 0;
  int writes_sent = 0;
  int live_items = 0;
  int commands_seen = 0;
  int frames_sent = 0;
  int frames_spoiled = 0;
  int cfg_writes = 0;
  int send_gap_pct = 0;
  int stall_pct = 0;

  // directed writes; phases that can be read straight off the windows are typed in
  dir_row_t dir_table [0:26] = '{
    // mute flags and the unused port
    {PORT_MUTE_LEFT,  1'b1, 16'd0,      1'b1, 1'b0, 8'd0, 1'b1, 1'b0, PH_CODE_IDLE},
    {PORT_MUTE_RIGHT, 1'b1, 16'hFFFF,   1'b1, 1'b0, 8'd0, 1'b1, 1'b1, PH_CODE_IDLE},
    {PORT_MUTE_LEFT,  1'b0, 16'd0,      1'b1, 1'b0, 8'd0, 1'b0, 1'b1, PH_CODE_IDLE},
    {PORT_UNUSED,     1'b1, 16'hFFFF,   1'b1, 1'b0, 8'd0, 1'b0, 1'b1, PH_CODE_IDLE},
    // same level as before, ignored
    {PORT_REMOTE,     1'b0, 16'hFFFF,   1'b1, 1'b0, 8'd0, 1'b0, 1'b1, PH_CODE_IDLE},
    {PORT_MUTE_RIGHT, 1'b0, 16'd0,      1'b1, 1'b0, 8'd0, 1'b0, 1'b0, PH_CODE_IDLE},
    // rising edge from idle starts the header pulse
    {PORT_REMOTE,     1'b1, 16'hFFFF,   1'b1, 1'b0, 8'd0, 1'b0, 1'b0, PH_CODE_HDR_PULSE},
    {PORT_REMOTE,     1'b1, 16'd0,      1'b1, 1'b0, 8'd0, 1'b0, 1'b0, PH_CODE_HDR_PULSE},
    // header pulse just too short, then just too long
    {PORT_REMOTE,     1'b0, 16'd5799,   1'b1, 1'b0, 8'd0, 1'b0, 1'b0, PH_CODE_IDLE},
    {PORT_REMOTE,     1'b1, 16'd0,      1'b1, 1'b0, 8'd0, 1'b0, 1'b0, PH_CODE_HDR_PULSE},
    {PORT_REMOTE,     1'b0, 16'd11200,  1'b1, 1'b0, 8'd0, 1'b0, 1'b0, PH_CODE_IDLE},
    // longest header pulse, header space past its window
    {PORT_REMOTE,     1'b1, 16'd0,      1'b0, 1'b0, 8'd0, 1'b0, 1'b0, PH_CODE_IDLE},
    {PORT_REMOTE,     1'b0, 16'd11199,  1'b0, 1'b0, 8'd0, 1'b0, 1'b0, PH_CODE_IDLE},
    {PORT_REMOTE,     1'b1, 16'd6200,   1'b1, 1'b0, 8'd0, 1'b0, 1'b0, PH_CODE_IDLE},
    // falling edge while idle
    {PORT_REMOTE,     1'b0, 16'd0,      1'b0, 1'b0, 8'd0, 1'b0, 1'b0, PH_CODE_IDLE},
    // shortest header pulse, header space one short
    {PORT_REMOTE,     1'b1, 16'd0,      1'b0, 1'b0, 8'd0, 1'b0, 1'b0, PH_CODE_IDLE},
    {PORT_REMOTE,     1'b0, 16'd5800,   1'b0, 1'b0, 8'd0, 1'b0, 1'b0, PH_CODE_IDLE},
    {PORT_REMOTE,     1'b1, 16'd3399,   1'b1, 1'b0, 8'd0, 1'b0, 1'b0, PH_CODE_IDLE},
    // into the bit phases with window edges: one at its top, zero at its bottom
    {PORT_REMOTE,     1'b0, 16'd0,      1'b0, 1'b0, 8'd0, 1'b0, 1'b0, PH_CODE_IDLE},
    {PORT_REMOTE,     1'b1, 16'd0,      1'b0, 1'b0, 8'd0, 1'b0, 1'b0, PH_CODE_IDLE},
    {PORT_REMOTE,     1'b0, 16'd5800,   1'b0, 1'b0, 8'd0, 1'b0, 1'b0, PH_CODE_IDLE},
    {PORT_REMOTE,     1'b1, 16'd3400,   1'b0, 1'b0, 8'd0, 1'b0, 1'b0, PH_CODE_IDLE},
    {PORT_REMOTE,     1'b0, 16'd1069,   1'b0, 1'b0, 8'd0, 1'b0, 1'b0, PH_CODE_IDLE},
    {PORT_REMOTE,     1'b1, 16'd4719,   1'b0, 1'b0, 8'd0, 1'b0, 1'b0, PH_CODE_IDLE},
    {PORT_REMOTE,     1'b0, 16'd380,    1'b0, 1'b0, 8'd0, 1'b0, 1'b0, PH_CODE_IDLE},
    {PORT_REMOTE,     1'b1, 16'd300,    1'b0, 1'b0, 8'd0, 1'b0, 1'b0, PH_CODE_IDLE},
    // bit pulse one past its window drops back to idle
    {PORT_REMOTE,     1'b0, 16'd1070,   1'b1, 1'b0, 8'd0, 1'b0, 1'b0, PH_CODE_IDLE}
  };

  // model of one write: updates the mirrored state and returns the result it owes
  function automatic out_item_t decode_write(input in_item_t item);
    out_item_t   res;
    logic [15:0] t;
    logic        hit;
    logic        keep;
    t = item.elapsed_us;
    hit = 1'b0;
    keep = 1'b0;
    case (item.req_type)
      PORT_REMOTE: begin
        if (item.line_level != lvl_q) begin
          lvl_q = item.line_level;
          case (phase_q)
            PH_CODE_IDLE: begin
              if (item.line_level) begin
                frame_bits = '0;
                bits_seen = '0;
                phase_q = PH_CODE_HDR_PULSE;
              end
            end
            PH_CODE_HDR_PULSE:
              phase_q = (t >= HDR_PULSE_MIN && t < HDR_PULSE_MAX) ? PH_CODE_HDR_SPACE
                                                                  : PH_CODE_IDLE;
            PH_CODE_HDR_SPACE:
              phase_q = (t >= HDR_SPACE_MIN && t < HDR_SPACE_MAX) ? PH_CODE_BIT_PULSE
                                                                  : PH_CODE_IDLE;
            PH_CODE_BIT_PULSE:
              phase_q = (t >= BIT_PULSE_MIN && t < BIT_PULSE_MAX) ? PH_CODE_BIT_SPACE
                                                                  : PH_CODE_IDLE;
            PH_CODE_BIT_SPACE: begin
              // long space is a one, mid space a zero, anything else aborts
              if (t >= ONE_SPACE_MIN && t < ONE_SPACE_MAX) begin
                if (bits_seen < FRAME_BITS) frame_bits[bits_seen[4:0]] = 1'b1;
                keep = 1'b1;
              end else if (t < ZERO_SPACE_MIN || t >= ZERO_SPACE_MAX) begin
                phase_q = PH_CODE_IDLE;
              end else begin
                keep = 1'b1;
              end
              if (keep) begin
                // the space after bit 32 closes the frame, its own bit is dropped
                if (bits_seen == FRAME_BITS) begin
                  hit = (frame_bits[7:0] == ~frame_bits[15:8]) &&
                        (frame_bits[7:0] == dev_addr) &&
                        (frame_bits[23:16] == ~frame_bits[31:24]);
                  phase_q = PH_CODE_IDLE;
                end else begin
                  phase_q = PH_CODE_BIT_PULSE;
                end
                bits_seen = bits_seen + 6'd1;
              end
            end
            default: ;
          endcase
        end
      end
      PORT_MUTE_LEFT:  left_q = item.line_level;
      PORT_MUTE_RIGHT: right_q = item.line_level;
      default: ;
    endcase
    res.command_valid = hit;
    res.command_code  = hit ? frame_bits[23:16] : 8'd0;
    res.mute_left     = left_q;
    res.mute_right    = right_q;
    res.decoder_phase = phase_q;
    return res;
  endfunction

  // present one write at a falling edge and hold it until the transfer
  task automatic push_item(input in_item_t item, input logic fixed = 1'b0,
                           input out_item_t fixed_res = '0);
    out_item_t pred;
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    // every write counts toward the random budget
    live_items++;
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    pred = decode_write(item);
    reports_due.push_back(fixed ? fixed_res : pred);
    writes_sent++;
    @(negedge clk);
  endtask

  // stop sending and let every owed result come back, plus the pipeline depth
  task automatic drain();
    in_valid <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_address(input logic [7:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    dev_addr = value;
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] pick_inside(input logic [15:0] lo, input logic [15:0] hi);
    case ($urandom_range(0, 3))
      0:       return lo;
      1:       return hi - 16'd1;
      default: return 16'($urandom_range(lo, hi - 16'd1));
    endcase
  endfunction

  function automatic logic [15:0] pick_outside(input logic [15:0] lo, input logic [15:0] hi);
    case ($urandom_range(0, 3))
      0:       return lo - 16'd1;
      1:       return hi;
      2:       return 16'($urandom_range(0, lo - 16'd1));
      default: return 16'($urandom_range(hi, 16'hFFFF));
    endcase
  endfunction

  // bit space widths that abort: below the zero window, in the gap, above the one window
  function automatic logic [15:0] bad_bit_space();
    case ($urandom_range(0, 6))
      0:       return ZERO_SPACE_MIN - 16'd1;
      1:       return ZERO_SPACE_MAX;
      2:       return ONE_SPACE_MIN - 16'd1;
      3:       return ONE_SPACE_MAX;
      4:       return 16'($urandom_range(0, ZERO_SPACE_MIN - 16'd1));
      5:       return 16'($urandom_range(ZERO_SPACE_MAX, ONE_SPACE_MIN - 16'd1));
      default: return 16'($urandom_range(ONE_SPACE_MAX, 16'hFFFF));
    endcase
  endfunction

  // bring the line low with the decoder idle; a zero width aborts any phase
  task automatic settle_line();
    while (phase_q != PH_CODE_IDLE || lvl_q) begin
      if (phase_q != PH_CODE_IDLE) push_item({PORT_REMOTE, ~lvl_q, 16'd0});
      else push_item({PORT_REMOTE, 1'b0, 16'($urandom)});
    end
  endtask

  // one full frame of 69 edges: start, header pulse and space, 33 pulse and space pairs
  // when spoiled, one randomly chosen width falls outside its window and the frame stops there
  task automatic send_frame(input logic spoil);
    logic [31:0] word;
    logic [7:0]  addr;
    logic [7:0]  code;
    logic [15:0] w;
    logic        lvl;
    logic        bit_val;
    logic        stop;
    int          bad_edge;
    int          k;
    int          j;
    int          flip;
    addr = ($urandom_range(0, 99) < 80) ? dev_addr : 8'($urandom);
    code = 8'($urandom);
    word = {~code, code, ~addr, addr};
    // sometimes break a complement so the frame is decoded but refused
    if ($urandom_range(0, 99) < 15) begin
      flip = $urandom_range(8, 31);
      word[flip] = ~word[flip];
    end
    bad_edge = spoil ? $urandom_range(1, 68) : -1;
    frames_sent++;
    if (spoil) frames_spoiled++;
    settle_line();
    stop = 1'b0;
    for (k = 0; k <= 68 && !stop; k++) begin
      lvl = (k % 2 == 0);
      if (k == 0) begin
        w = 16'($urandom);
      end else if (k == 1) begin
        w = (k == bad_edge) ? pick_outside(HDR_PULSE_MIN, HDR_PULSE_MAX)
                            : pick_inside(HDR_PULSE_MIN, HDR_PULSE_MAX);
      end else if (k == 2) begin
        w = (k == bad_edge) ? pick_outside(HDR_SPACE_MIN, HDR_SPACE_MAX)
                            : pick_inside(HDR_SPACE_MIN, HDR_SPACE_MAX);
      end else if (k % 2 == 1) begin
        w = (k == bad_edge) ? pick_outside(BIT_PULSE_MIN, BIT_PULSE_MAX)
                            : pick_inside(BIT_PULSE_MIN, BIT_PULSE_MAX);
      end else begin
        j = (k - 4) / 2;
        // the closing space carries a bit that is never stored
        if (j < 32) bit_val = word[j];
        else bit_val = 1'($urandom);
        if (k == bad_edge) w = bad_bit_space();
        else if (bit_val) w = pick_inside(ONE_SPACE_MIN, ONE_SPACE_MAX);
        else w = pick_inside(ZERO_SPACE_MIN, ZERO_SPACE_MAX);
      end
      // mute writes and repeated levels slipped in between edges
      if ($urandom_range(0, 99) < 4)
        push_item({($urandom_range(0, 1) ? PORT_MUTE_LEFT : PORT_MUTE_RIGHT),
                   1'($urandom), 16'($urandom)});
      if ($urandom_range(0, 99) < 3) push_item({PORT_REMOTE, lvl_q, 16'($urandom)});
      push_item({PORT_REMOTE, lvl, w});
      stop = (k == bad_edge);
    end
  endtask

  // receiver side: ready changes at the falling edge only
  always @(negedge clk) out_ready <= ($urandom_range(0, 99) >= stall_pct);

  // result checker: every result transfer is matched against the oldest owed result
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (reports_due.size() == 0) begin
        if (errors < 10) $display("unexpected result at %0t: %h", $time, out_data);
        errors++;
      end else begin
        want = reports_due.pop_front();
        if (out_data.command_valid !== want.command_valid ||
            out_data.command_code  !== want.command_code  ||
            out_data.mute_left     !== want.mute_left     ||
            out_data.mute_right    !== want.mute_right    ||
            out_data.decoder_phase !== want.decoder_phase) begin
          if (errors < 10) begin
            $display("mismatch at %0t: expected valid %0b code %h mutes %0b%0b phase %0d",
                     $time, want.command_valid, want.command_code, want.mute_left,
                     want.mute_right, want.decoder_phase);
            $display("  got valid %0b code %h mutes %0b%0b phase %0d",
                     out_data.command_valid, out_data.command_code, out_data.mute_left,
                     out_data.mute_right, out_data.decoder_phase);
          end
          errors++;
        end
        if (out_data.command_valid === 1'b1) commands_seen++;
      end
    end
  end

  // idling plan per random phase: none, sender only, receiver only, both
  int          gap_plan   [0:3] = '{0, 48, 0, 28};
  int          stall_plan [0:3] = '{0, 0, 48, 28};
  logic [7:0]  addr_plan  [0:3];

  initial begin
    int guard;
    int pick;
    int p;
    addr_plan = '{8'h00, 8'hFF, 8'($urandom), DEVICE_ADDRESS_RESET};

    // synchronous reset held low, then released at a falling edge
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table at the reset address
    foreach (dir_table[i]) push_item(dir_table[i].item, dir_table[i].chk, dir_table[i].res);

    // random phases, each after a new address while the block is idle
    for (p = 0; p < 4; p++) begin
      write_address(addr_plan[p]);
      send_gap_pct = gap_plan[p];
      stall_pct    = stall_plan[p];
      live_items   = 0;
      while (live_items < 170) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          send_frame(1'b0);
        end else if (pick < 85) begin
          send_frame(1'b1);
        end else begin
          // noise burst: any port, any level, any width
          repeat ($urandom_range(1, 8))
            push_item({2'($urandom_range(0, 3)), 1'($urandom), 16'($urandom)});
        end
      end
    end

    // wind down: wait for the last results, then the pipeline depth
    in_valid <= 1'b0;
    for (guard = 0; reports_due.size() != 0 && guard < 20000; guard++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (reports_due.size() != 0) begin
      $display("%0d results never arrived", reports_due.size());
      errors += reports_due.size();
    end

    $display("covered %0d writes over %0d address settings and four idling patterns",
             writes_sent, cfg_writes + 1);
    $display("%0d frames sent (%0d spoiled), %0d commands accepted, %0d failures",
             frames_sent, frames_spoiled, commands_seen, errors);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
